FILE: rtl/core/dtmf_call_relay_controller_defines.svh
// Assertion macros used by the checker file of the call relay controller.
`ifndef DTMF_CALL_RELAY_CONTROLLER_DEFINES_SVH
`define DTMF_CALL_RELAY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DCRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DCRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/dcrc_pkg.sv
package dcrc_pkg;

   // Field widths
   localparam int OP_W       = 3;
   localparam int DIGIT_W    = 4;
   localparam int MAX_DIGITS = 16;
   localparam int NUM_W      = 64;
   localparam int LEN_W      = 5;
   localparam int KEY_W      = 8;
   localparam int TICK_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // Event codes
   localparam logic [OP_W-1:0] OP_RING   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLIP   = 3'd1;
   localparam logic [OP_W-1:0] OP_KEY    = 3'd2;
   localparam logic [OP_W-1:0] OP_HANGUP = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

   // Key codes (ASCII)
   localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
   localparam logic [KEY_W-1:0] KEY_ONE   = 8'h31;
   localparam logic [KEY_W-1:0] KEY_TWO   = 8'h32;
   localparam logic [KEY_W-1:0] KEY_THREE = 8'h33;
   localparam logic [KEY_W-1:0] KEY_FOUR  = 8'h34;
   localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;
   localparam logic [KEY_W-1:0] KEY_STAR  = 8'h2A;
   localparam logic [KEY_W-1:0] KEY_HASH  = 8'h23;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_WAIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CALL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_NUM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_LEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POLARITY    = 3'd4;

   // Register reset values
   localparam logic [TICK_W-1:0] CLIP_WAIT_RST = 24'd4000;
   localparam logic [TICK_W-1:0] MAX_CALL_RST  = 24'd120000;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RING = 2'd1,
      PH_CALL = 2'd2
   } phase_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [NUM_W-1:0] caller_digits;
      logic [LEN_W-1:0] caller_length;
      logic [KEY_W-1:0] key_char;
   } req_type;

   typedef struct packed {
      logic [1:0] relay_levels;
      logic [1:0] relays_on;
      logic [1:0] call_phase;
      logic       answer_cmd;
      logic       hangup_cmd;
      logic       status_request;
      logic       unknown_key;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] clip_wait_ticks;
      logic [TICK_W-1:0] max_call_ticks;
      logic [NUM_W-1:0]  allowed_number;
      logic [LEN_W-1:0]  allowed_length;
      logic              drive_active_high;
   } cfg_type;

endpackage

FILE: rtl/core/dcrc_match.sv
module dcrc_match (
   input  logic [dcrc_pkg::NUM_W-1:0] caller_digits,
   input  logic [dcrc_pkg::LEN_W-1:0] caller_length,
   input  logic [dcrc_pkg::NUM_W-1:0] allowed_number,
   input  logic [dcrc_pkg::LEN_W-1:0] allowed_length,
   output logic                       match
);
   import dcrc_pkg::*;

   logic digits_ok;

   // every digit below the length must agree
   always_comb begin
      digits_ok = 1'b1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (LEN_W'(i) < caller_length &&
             caller_digits[DIGIT_W*i +: DIGIT_W] != allowed_number[DIGIT_W*i +: DIGIT_W]) begin
            digits_ok = 1'b0;
         end
      end
   end

   // empty authorized number lets any caller in
   assign match = (allowed_length == '0) ||
                  (allowed_length <= LEN_W'(MAX_DIGITS) &&
                   caller_length == allowed_length && digits_ok);

endmodule

FILE: rtl/core/dcrc_core.sv
module dcrc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  dcrc_pkg::req_type item,
   input  dcrc_pkg::cfg_type cfg,
   output dcrc_pkg::rsp_type result
);
   import dcrc_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic              seen_ff, seen_in;
   logic [1:0]        relay_ff, relay_in;
   logic              match;
   logic              answer, hangup, status, unknown;

   dcrc_match u_match (
      .caller_digits  (item.caller_digits),
      .caller_length  (item.caller_length),
      .allowed_number (cfg.allowed_number),
      .allowed_length (cfg.allowed_length),
      .match          (match)
   );

   // saturating tick count
   assign elapsed_inc = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // event decode and next state
   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      seen_in    = seen_ff;
      relay_in   = relay_ff;
      answer     = 1'b0;
      hangup     = 1'b0;
      status     = 1'b0;
      unknown    = 1'b0;
      case (item.op)
         OP_RING: begin
            if (phase_ff == PH_IDLE) begin
               phase_in   = PH_RING;
               elapsed_in = '0;
               seen_in    = 1'b0;
            end
         end
         OP_CLIP: begin
            if (phase_ff == PH_RING) begin
               seen_in = 1'b1;
               if (match) begin
                  answer     = 1'b1;
                  phase_in   = PH_CALL;
                  elapsed_in = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         OP_KEY: begin
            if (phase_ff == PH_CALL) begin
               case (item.key_char)
                  KEY_ONE:   relay_in = relay_ff | 2'b01;
                  KEY_TWO:   relay_in = relay_ff & 2'b10;
                  KEY_THREE: relay_in = relay_ff | 2'b10;
                  KEY_FOUR:  relay_in = relay_ff & 2'b01;
                  KEY_STAR:  relay_in = 2'b11;
                  KEY_ZERO:  relay_in = 2'b00;
                  KEY_NINE:  status   = 1'b1;
                  KEY_HASH: begin
                     hangup   = 1'b1;
                     phase_in = PH_IDLE;
                  end
                  default:   unknown  = 1'b1;
               endcase
            end
         end
         OP_HANGUP: begin
            phase_in = PH_IDLE;
         end
         OP_TICK: begin
            elapsed_in = elapsed_inc;
            // a ring timeout that answers restarts the count, so no call timeout then
            if (phase_ff == PH_RING && !seen_ff && elapsed_inc > cfg.clip_wait_ticks) begin
               if (cfg.allowed_length == '0) begin
                  answer     = 1'b1;
                  phase_in   = PH_CALL;
                  elapsed_in = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else if (phase_ff == PH_CALL && elapsed_inc > cfg.max_call_ticks) begin
               hangup   = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: ;
      endcase
   end

   // result of this item, pin levels after polarity
   always_comb begin
      result.relays_on      = relay_in;
      result.relay_levels   = cfg.drive_active_high ? relay_in : ~relay_in;
      result.call_phase     = phase_in;
      result.answer_cmd     = answer;
      result.hangup_cmd     = hangup;
      result.status_request = status;
      result.unknown_key    = unknown;
   end

   // call state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         seen_ff    <= 1'b0;
         relay_ff   <= 2'b00;
      end else if (fire) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         seen_ff    <= seen_in;
         relay_ff   <= relay_in;
      end
   end

endmodule

FILE: rtl/core/dtmf_call_relay_controller.sv
// Call-control block for a phone-operated two-relay box. It takes one event item
// (ring, caller ID, key, remote hangup, millisecond tick) per clock cycle while
// rsp_ready is high, and returns exactly one result item per event, in order. An
// accepted item is held in an input register, evaluated in one pass of shallow
// logic against the call state, and its result is written to an output register;
// the output register lets the next item enter while a result waits for the
// consumer. Sustained rate is one item per cycle while rsp_ready stays high, set
// by the state update between input and output registers. Configuration
// writes take effect at once and should only be issued while no item is pending.
module dtmf_call_relay_controller (
   input  logic                            clock,
   input  logic                            reset,
   // event items
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dcrc_pkg::OP_W-1:0]       req_op,
   input  logic [dcrc_pkg::NUM_W-1:0]      req_caller_digits,
   input  logic [dcrc_pkg::LEN_W-1:0]      req_caller_length,
   input  logic [dcrc_pkg::KEY_W-1:0]      req_key_char,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_relay_levels,
   output logic [1:0]                      rsp_relays_on,
   output logic [1:0]                      rsp_call_phase,
   output logic                            rsp_answer_cmd,
   output logic                            rsp_hangup_cmd,
   output logic                            rsp_status_request,
   output logic                            rsp_unknown_key,
   // configuration
   input  logic                            csr_wen,
   input  logic [dcrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dcrc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dcrc_pkg::*;

   cfg_type cfg_ff;
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   logic    advance;

   // input register moves on when the output register is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_wait_ticks   <= CLIP_WAIT_RST;
         cfg_ff.max_call_ticks    <= MAX_CALL_RST;
         cfg_ff.allowed_number    <= '0;
         cfg_ff.allowed_length    <= '0;
         cfg_ff.drive_active_high <= 1'b1;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_CLIP_WAIT:   cfg_ff.clip_wait_ticks   <= csr_wdata[TICK_W-1:0];
            CSR_MAX_CALL:    cfg_ff.max_call_ticks    <= csr_wdata[TICK_W-1:0];
            CSR_ALLOWED_NUM: cfg_ff.allowed_number    <= csr_wdata[NUM_W-1:0];
            CSR_ALLOWED_LEN: cfg_ff.allowed_length    <= csr_wdata[LEN_W-1:0];
            CSR_POLARITY:    cfg_ff.drive_active_high <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.op            <= req_op;
         req_ff.caller_digits <= req_caller_digits;
         req_ff.caller_length <= req_caller_length;
         req_ff.key_char      <= req_key_char;
      end
   end

   dcrc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (req_ff),
      .cfg    (cfg_ff),
      .result (rsp_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_relay_levels   = rsp_ff.relay_levels;
   assign rsp_relays_on      = rsp_ff.relays_on;
   assign rsp_call_phase     = rsp_ff.call_phase;
   assign rsp_answer_cmd     = rsp_ff.answer_cmd;
   assign rsp_hangup_cmd     = rsp_ff.hangup_cmd;
   assign rsp_status_request = rsp_ff.status_request;
   assign rsp_unknown_key    = rsp_ff.unknown_key;

endmodule

FILE: rtl/core/dcrc_checker.sv
`include "dtmf_call_relay_controller_defines.svh"

module dcrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_relays_on,
   input logic [1:0] rsp_call_phase,
   input logic       rsp_answer_cmd,
   input logic       rsp_hangup_cmd,
   input logic       rsp_status_request,
   input logic       rsp_unknown_key
);
   import dcrc_pkg::*;

   // an answer always leaves the block in a call
   `DCRC_ASSERT_NOW(a_answer_in_call, clock, reset, rsp_valid && rsp_answer_cmd, rsp_call_phase == PH_CALL, "answer without call phase")

   // our own hangup always returns to idle
   `DCRC_ASSERT_NOW(a_hangup_idle, clock, reset, rsp_valid && rsp_hangup_cmd, rsp_call_phase == PH_IDLE, "hangup without idle phase")

   // key flags only while a call stays up
   `DCRC_ASSERT_NOW(a_key_flags_call, clock, reset, rsp_valid && (rsp_status_request || rsp_unknown_key), rsp_call_phase == PH_CALL, "key flag outside call")

   // a stalled item holds
   `DCRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_relays_on) && $stable(rsp_call_phase), "result item changed while stalled")

endmodule

bind dtmf_call_relay_controller dcrc_checker u_dcrc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_relays_on      (rsp_relays_on),
   .rsp_call_phase     (rsp_call_phase),
   .rsp_answer_cmd     (rsp_answer_cmd),
   .rsp_hangup_cmd     (rsp_hangup_cmd),
   .rsp_status_request (rsp_status_request),
   .rsp_unknown_key    (rsp_unknown_key)
);
